// File: rtl/core/rlmc_pkg.sv
package rlmc_pkg;

   localparam int BRIGHT_W     = 7;
   localparam int LEVEL_W      = 8;
   localparam int PCT_FULL     = 100;
   localparam int DUTY_FULL    = 255;
   localparam int BRIGHT_RESET = 50;

   // dynamic cycle bounds
   localparam logic [LEVEL_W-1:0] DYN_RED_MIN = 8'd50;
   localparam logic [LEVEL_W-1:0] DYN_RED_MAX = 8'd150;
   localparam logic [LEVEL_W-1:0] DYN_GB_MAX  = 8'd100;

   // reset colour
   localparam logic [LEVEL_W-1:0] RST_RED   = 8'd10;
   localparam logic [LEVEL_W-1:0] RST_GREEN = 8'd100;
   localparam logic [LEVEL_W-1:0] RST_BLUE  = 8'd150;

   // queue between front and back, depth at least 2
   localparam int Q_DEPTH = 2;
   localparam int QPTR_W  = $clog2(Q_DEPTH);
   localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

   typedef enum logic [2:0] {
      OP_TICK   = 3'd0,
      OP_KEY    = 3'd1,
      OP_ON     = 3'd2,
      OP_OFF    = 3'd3,
      OP_MODE   = 3'd4,
      OP_COLOUR = 3'd5
   } opcode_type;

   typedef enum logic [1:0] {
      MODE_WHITE   = 2'd0,
      MODE_YELLOW  = 2'd1,
      MODE_STATIC  = 2'd2,
      MODE_DYNAMIC = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      KIND_NOP,
      KIND_TICK,
      KIND_KEY,
      KIND_ON,
      KIND_OFF,
      KIND_MODE,
      KIND_COLOUR
   } kind_type;

   typedef enum logic [2:0] {
      PH_RED_UP   = 3'd0,
      PH_GREEN_DN = 3'd1,
      PH_BLUE_UP  = 3'd2,
      PH_RED_DN   = 3'd3,
      PH_GREEN_UP = 3'd4,
      PH_BLUE_DN  = 3'd5
   } phase_type;

   typedef struct packed {
      kind_type            kind;
      mode_type            mode_sel;
      logic [LEVEL_W-1:0]  red;
      logic [LEVEL_W-1:0]  green;
      logic [LEVEL_W-1:0]  blue;
   } item_type;

   typedef logic [LEVEL_W-1:0] scale_lut_type [2**BRIGHT_W];

   // percent (capped at full) to duty, built at elaboration
   function automatic scale_lut_type build_scale_lut();
      scale_lut_type lut;
      int            p;
      for (int i = 0; i < 2**BRIGHT_W; i++) begin
         p = (i > PCT_FULL) ? PCT_FULL : i;
         lut[i] = LEVEL_W'((p * DUTY_FULL) / PCT_FULL);
      end
      return lut;
   endfunction

   localparam scale_lut_type SCALE_LUT = build_scale_lut();

endpackage

// File: rtl/core/rlmc_if.sv
interface rlmc_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] opcode;
   logic [1:0] mode_sel;
   logic [7:0] red_in;
   logic [7:0] green_in;
   logic [7:0] blue_in;

   modport source (output valid, opcode, mode_sel, red_in, green_in, blue_in, input ready);
   modport sink   (input valid, opcode, mode_sel, red_in, green_in, blue_in, output ready);
endinterface

interface rlmc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] red_pwm;
   logic [7:0] green_pwm;
   logic [7:0] blue_pwm;
   logic [7:0] white_pwm;
   logic [7:0] yellow_pwm;
   logic       lamp_is_on;
   logic [1:0] active_mode;

   modport source (output valid, red_pwm, green_pwm, blue_pwm, white_pwm, yellow_pwm,
                   lamp_is_on, active_mode, input ready);
   modport sink   (input valid, red_pwm, green_pwm, blue_pwm, white_pwm, yellow_pwm,
                   lamp_is_on, active_mode, output ready);
endinterface

interface rlmc_csr_if;
   logic       valid;
   logic       ready;
   logic [6:0] bright_pct;

   modport source (output valid, bright_pct, input ready);
   modport sink   (input valid, bright_pct, output ready);
endinterface

// File: rtl/core/rlmc_front.sv
module rlmc_front
   import rlmc_pkg::*;
(
   rlmc_req_if.sink    req_bus,
   output logic        push_valid,
   output item_type    push_item,
   input  logic        push_ready
);

   always_comb begin
      push_item.mode_sel = mode_type'(req_bus.mode_sel);
      push_item.red      = req_bus.red_in;
      push_item.green    = req_bus.green_in;
      push_item.blue     = req_bus.blue_in;
      unique case (req_bus.opcode)
         OP_TICK:   push_item.kind = KIND_TICK;
         OP_KEY:    push_item.kind = KIND_KEY;
         OP_ON:     push_item.kind = KIND_ON;
         OP_OFF:    push_item.kind = KIND_OFF;
         OP_MODE:   push_item.kind = KIND_MODE;
         OP_COLOUR: push_item.kind = KIND_COLOUR;
         default:   push_item.kind = KIND_NOP;
      endcase
   end

   assign push_valid    = req_bus.valid;
   assign req_bus.ready = push_ready;

endmodule

// File: rtl/core/rlmc_queue.sv
module rlmc_queue
   import rlmc_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push_valid,
   input  item_type push_item,
   output logic     push_ready,
   output logic     pop_valid,
   output item_type pop_item,
   input  logic     pop_ready
);

   item_type            entry_ff [Q_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                push, pop;

   function automatic logic [QPTR_W-1:0] ptr_next(logic [QPTR_W-1:0] p);
      return (p == QPTR_W'(Q_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign push_ready = (count_ff != QCNT_W'(Q_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// File: rtl/core/rlmc_back.sv
module rlmc_back
   import rlmc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               pop_valid,
   input  item_type           pop_item,
   output logic               pop_ready,
   input  logic [LEVEL_W-1:0] scaled_duty,
   rlmc_rsp_if.source         rsp_bus
);

   logic               on_ff, on_in;
   mode_type           mode_ff, mode_in;
   phase_type          phase_ff, phase_in;
   logic [LEVEL_W-1:0] red_ff, red_in, green_ff, green_in, blue_ff, blue_in;
   logic [LEVEL_W-1:0] pwm_r_ff, pwm_r_in, pwm_g_ff, pwm_g_in, pwm_b_ff, pwm_b_in;
   logic [LEVEL_W-1:0] pwm_w_ff, pwm_w_in, pwm_y_ff, pwm_y_in;
   logic               out_valid_ff, out_valid_in;
   logic               pop;
   logic               preset, sw, on_req, off_req, tick, colour;
   mode_type           tgt;

   assign pop_ready = !out_valid_ff || rsp_bus.ready;
   assign pop       = pop_valid && pop_ready;

   // classify the popped item against the current state
   always_comb begin
      preset  = 1'b0;
      sw      = 1'b0;
      on_req  = 1'b0;
      off_req = 1'b0;
      tick    = 1'b0;
      colour  = 1'b0;
      tgt     = MODE_WHITE;
      if (pop) begin
         unique case (pop_item.kind)
            KIND_TICK:   tick = on_ff && (mode_ff == MODE_DYNAMIC);
            KIND_ON:     on_req = 1'b1;
            KIND_OFF:    off_req = 1'b1;
            KIND_COLOUR: colour = 1'b1;
            KIND_MODE: begin
               sw  = 1'b1;
               tgt = pop_item.mode_sel;
            end
            KIND_KEY: begin
               if (!on_ff) begin
                  // turn on in white mode: dynamic leaves its preset behind
                  preset = (mode_ff == MODE_DYNAMIC);
                  sw     = 1'b1;
                  tgt    = MODE_WHITE;
               end else begin
                  unique case (mode_ff)
                     MODE_WHITE: begin
                        sw  = 1'b1;
                        tgt = MODE_YELLOW;
                     end
                     MODE_YELLOW: begin
                        sw  = 1'b1;
                        tgt = MODE_DYNAMIC;
                     end
                     MODE_DYNAMIC: begin
                        sw  = 1'b1;
                        tgt = MODE_STATIC;
                     end
                     default: off_req = 1'b1;
                  endcase
               end
            end
            default: ;
         endcase
      end
   end

   // carry out the action
   always_comb begin
      on_in    = on_ff;
      mode_in  = mode_ff;
      phase_in = phase_ff;
      red_in   = red_ff;
      green_in = green_ff;
      blue_in  = blue_ff;
      pwm_r_in = pwm_r_ff;
      pwm_g_in = pwm_g_ff;
      pwm_b_in = pwm_b_ff;
      pwm_w_in = pwm_w_ff;
      pwm_y_in = pwm_y_ff;

      if (preset) begin
         red_in   = DYN_RED_MIN;
         green_in = DYN_GB_MAX;
         blue_in  = '0;
         phase_in = PH_RED_UP;
      end
      if (colour) begin
         red_in   = pop_item.red;
         green_in = pop_item.green;
         blue_in  = pop_item.blue;
      end
      if (tick) begin
         // test old value, then step with 8-bit wrap
         case (phase_ff)
            PH_RED_UP: begin
               red_in = red_ff + 1'b1;
               if (red_ff >= DYN_RED_MAX) phase_in = PH_GREEN_DN;
            end
            PH_GREEN_DN: begin
               green_in = green_ff - 1'b1;
               if (green_ff <= 8'd1) phase_in = PH_BLUE_UP;
            end
            PH_BLUE_UP: begin
               blue_in = blue_ff + 1'b1;
               if (blue_ff >= DYN_GB_MAX) phase_in = PH_RED_DN;
            end
            PH_RED_DN: begin
               red_in = red_ff - 1'b1;
               if (red_ff <= DYN_RED_MIN + 8'd1) phase_in = PH_GREEN_UP;
            end
            PH_GREEN_UP: begin
               green_in = green_ff + 1'b1;
               if (green_ff >= DYN_GB_MAX) phase_in = PH_BLUE_DN;
            end
            PH_BLUE_DN: begin
               blue_in = blue_ff - 1'b1;
               if (blue_ff <= 8'd1) phase_in = PH_RED_UP;
            end
            default: ;
         endcase
         pwm_r_in = red_in;
         pwm_g_in = green_in;
         pwm_b_in = blue_in;
      end
      if (off_req || sw) begin
         pwm_r_in = '0;
         pwm_g_in = '0;
         pwm_b_in = '0;
         pwm_w_in = '0;
         pwm_y_in = '0;
         on_in    = 1'b0;
      end
      if (sw) begin
         mode_in = tgt;
      end
      if (on_req || sw) begin
         unique case (mode_in)
            MODE_WHITE:  pwm_w_in = scaled_duty;
            MODE_YELLOW: pwm_y_in = scaled_duty;
            MODE_STATIC: begin
               pwm_r_in = red_in;
               pwm_g_in = green_in;
               pwm_b_in = blue_in;
            end
            default: begin
               red_in   = DYN_RED_MIN;
               green_in = DYN_GB_MAX;
               blue_in  = '0;
               phase_in = PH_RED_UP;
            end
         endcase
         on_in = 1'b1;
      end

      out_valid_in = pop || (out_valid_ff && !rsp_bus.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         on_ff        <= 1'b0;
         mode_ff      <= MODE_STATIC;
         phase_ff     <= PH_RED_UP;
         red_ff       <= RST_RED;
         green_ff     <= RST_GREEN;
         blue_ff      <= RST_BLUE;
         pwm_r_ff     <= '0;
         pwm_g_ff     <= '0;
         pwm_b_ff     <= '0;
         pwm_w_ff     <= '0;
         pwm_y_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         on_ff        <= on_in;
         mode_ff      <= mode_in;
         phase_ff     <= phase_in;
         red_ff       <= red_in;
         green_ff     <= green_in;
         blue_ff      <= blue_in;
         pwm_r_ff     <= pwm_r_in;
         pwm_g_ff     <= pwm_g_in;
         pwm_b_ff     <= pwm_b_in;
         pwm_w_ff     <= pwm_w_in;
         pwm_y_ff     <= pwm_y_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // result register, loaded with the state after each transaction
   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_bus.red_pwm     <= pwm_r_in;
         rsp_bus.green_pwm   <= pwm_g_in;
         rsp_bus.blue_pwm    <= pwm_b_in;
         rsp_bus.white_pwm   <= pwm_w_in;
         rsp_bus.yellow_pwm  <= pwm_y_in;
         rsp_bus.lamp_is_on  <= on_in;
         rsp_bus.active_mode <= mode_in;
      end
   end

   assign rsp_bus.valid = out_valid_ff;

endmodule

// File: rtl/core/rgb_lamp_mode_controller.sv
// channel   dir   handshake      payload
// req_bus   in    valid/ready    opcode, mode_sel, red_in, green_in, blue_in
// rsp_bus   out   valid/ready    red/green/blue/white/yellow_pwm, lamp_is_on, active_mode
// csr_bus   in    valid/ready    bright_pct (always ready)
//
// one transaction per cycle sustained while rsp_bus takes each result; a request is
// first written into the queue, then popped into the result register, and the
// result turns valid once it is in the result register
// the back end's state update bounds throughput
// synchronous active-high reset; no clearing pass, ready right after reset
// a stalled rsp_bus holds the result register, then the 2-entry queue fills,
// then req_bus.ready drops
module rgb_lamp_mode_controller
   import rlmc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   rlmc_req_if.sink    req_bus,
   rlmc_rsp_if.source  rsp_bus,
   rlmc_csr_if.sink    csr_bus
);

   logic               push_valid, push_ready;
   item_type           push_item;
   logic               pop_valid, pop_ready;
   item_type           pop_item;
   logic [LEVEL_W-1:0] scaled_ff, scaled_in;

   // brightness is kept as its duty value, capped at full scale on write
   assign csr_bus.ready = 1'b1;

   always_comb begin
      scaled_in = scaled_ff;
      if (csr_bus.valid) begin
         scaled_in = SCALE_LUT[csr_bus.bright_pct];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scaled_ff <= SCALE_LUT[BRIGHT_W'(BRIGHT_RESET)];
      end else begin
         scaled_ff <= scaled_in;
      end
   end

   // front: decode opcode into an action kind
   rlmc_front u_front (
      .req_bus    (req_bus),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_ready (push_ready)
   );

   // short queue decouples decode from execution
   rlmc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_item   (pop_item),
      .pop_ready  (pop_ready)
   );

   // back: lamp state, colour cycle and pwm latches
   rlmc_back u_back (
      .clock       (clock),
      .reset       (reset),
      .pop_valid   (pop_valid),
      .pop_item    (pop_item),
      .pop_ready   (pop_ready),
      .scaled_duty (scaled_ff),
      .rsp_bus     (rsp_bus)
   );

`ifndef ASSERT_OFF
   // an off lamp never shows a lit channel
   a_off_dark: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && !rsp_bus.lamp_is_on) |->
         (rsp_bus.red_pwm == '0 && rsp_bus.green_pwm == '0 && rsp_bus.blue_pwm == '0 &&
          rsp_bus.white_pwm == '0 && rsp_bus.yellow_pwm == '0))
      else $error("lamp off with nonzero pwm");

   // white mode lights only the white channel
   a_white_only: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.lamp_is_on && rsp_bus.active_mode == MODE_WHITE) |->
         (rsp_bus.red_pwm == '0 && rsp_bus.green_pwm == '0 && rsp_bus.blue_pwm == '0 &&
          rsp_bus.yellow_pwm == '0))
      else $error("white mode drives other channels");

   // yellow mode lights only the yellow channel
   a_yellow_only: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.lamp_is_on && rsp_bus.active_mode == MODE_YELLOW) |->
         (rsp_bus.red_pwm == '0 && rsp_bus.green_pwm == '0 && rsp_bus.blue_pwm == '0 &&
          rsp_bus.white_pwm == '0))
      else $error("yellow mode drives other channels");
`endif

endmodule
